[rtl/core/alle_pkg.sv]
// shared types, codes and microcode rom for the array linked-list engine
package alle_pkg;

  // stream word layout
  localparam int IN_TUSER_W  = 3;
  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TUSER_W = 2;
  localparam int OUT_TDATA_W = 80;
  localparam int IDX_W       = 11;
  localparam int VAL_W       = 56;
  localparam int ST_W        = 2;

  // bit offsets within tdata
  localparam int IN_NODE_LSB   = 0;
  localparam int IN_VALUE_LSB  = 11;
  localparam int IN_LINK_LSB   = 67;
  localparam int OUT_INDEX_LSB = 0;
  localparam int OUT_VALUE_LSB = 11;
  localparam int OUT_LINK_LSB  = 67;
  localparam int OUT_ST_LSB    = 78;

  // operation codes
  localparam logic [2:0] MODE_BEGIN  = 3'd0;
  localparam logic [2:0] MODE_LOAD   = 3'd1;
  localparam logic [2:0] MODE_INSERT = 3'd2;
  localparam logic [2:0] MODE_DELETE = 3'd3;
  localparam logic [2:0] MODE_READ   = 3'd4;

  // result kinds
  localparam logic [1:0] KIND_INSERT = 2'd0;
  localparam logic [1:0] KIND_DELETE = 2'd1;
  localparam logic [1:0] KIND_READ   = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  // null pointer
  localparam logic [IDX_W-1:0] NIL = '1;

  typedef enum logic [4:0] {
    UPC_IDLE,
    UPC_BEGIN,
    UPC_LOAD0,
    UPC_LOAD1,
    UPC_INS0,
    UPC_INS1,
    UPC_INS2,
    UPC_INS3,
    UPC_INS_HEAD,
    UPC_INS_FULL,
    UPC_DEL0,
    UPC_DEL1,
    UPC_DEL2,
    UPC_DEL3,
    UPC_DEL_HEAD,
    UPC_DEL_NONE,
    UPC_RD0,
    UPC_RD1,
    UPC_RD_OUT
  } upc_t;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_FULL,
    COND_NODE_OUT,
    COND_RD_OUT,
    COND_HEAD_IN
  } cond_t;

  typedef enum logic [1:0] {ADDR_NODE, ADDR_FREE, ADDR_VICTIM} addr_sel_t;
  typedef enum logic [1:0] {LWE_OFF, LWE_ON, LWE_IF_NODE} link_we_t;
  typedef enum logic [1:0] {LSRC_IN, LSRC_HEAD, LSRC_RD, LSRC_FREE} link_src_t;
  typedef enum logic [1:0] {HEAD_KEEP, HEAD_NODE, HEAD_FREE, HEAD_RD_IF_NO_NODE} head_op_t;
  typedef enum logic [1:0] {FREE_KEEP, FREE_CLR, FREE_INC} free_op_t;
  typedef enum logic [1:0] {VIC_KEEP, VIC_RD, VIC_HEAD} vic_op_t;

  typedef enum logic [2:0] {
    EMIT_NONE,
    EMIT_INS_OK,
    EMIT_INS_FULL,
    EMIT_DEL_OK,
    EMIT_DEL_NONE,
    EMIT_RD_OK,
    EMIT_RD_OUT
  } emit_t;

  // one control word
  typedef struct packed {
    cond_t     cond;
    upc_t      tgt;
    addr_sel_t addr;
    logic      mem_rd;
    logic      text_we;
    link_we_t  link_we;
    link_src_t link_src;
    head_op_t  head_op;
    free_op_t  free_op;
    vic_op_t   vic_op;
    emit_t     emit;
  } ctl_t;

  localparam ctl_t CTL_NOP = '{
    cond: COND_NEVER, tgt: UPC_IDLE, addr: ADDR_NODE, mem_rd: 1'b0,
    text_we: 1'b0, link_we: LWE_OFF, link_src: LSRC_IN, head_op: HEAD_KEEP,
    free_op: FREE_KEEP, vic_op: VIC_KEEP, emit: EMIT_NONE
  };

  // program entry per operation
  function automatic upc_t alle_entry(input logic [2:0] mode);
    upc_t e;
    case (mode)
      MODE_BEGIN:  e = UPC_BEGIN;
      MODE_LOAD:   e = UPC_LOAD0;
      MODE_INSERT: e = UPC_INS0;
      MODE_DELETE: e = UPC_DEL0;
      MODE_READ:   e = UPC_RD0;
      default:     e = UPC_IDLE;
    endcase
    return e;
  endfunction

  // microcode rom
  function automatic ctl_t alle_ucode(input upc_t pc);
    ctl_t w;
    w = CTL_NOP;
    case (pc)
      UPC_BEGIN: begin
        w.head_op = HEAD_NODE;
        w.free_op = FREE_CLR;
        w.cond    = COND_ALWAYS;
      end
      UPC_LOAD0: begin
        w.cond = COND_FULL;
      end
      UPC_LOAD1: begin
        w.addr     = ADDR_FREE;
        w.text_we  = 1'b1;
        w.link_we  = LWE_ON;
        w.link_src = LSRC_IN;
        w.free_op  = FREE_INC;
        w.cond     = COND_ALWAYS;
      end
      UPC_INS0: begin
        w.cond = COND_FULL;
        w.tgt  = UPC_INS_FULL;
      end
      UPC_INS1: begin
        w.addr   = ADDR_NODE;
        w.mem_rd = 1'b1;
        w.cond   = COND_NODE_OUT;
        w.tgt    = UPC_INS_HEAD;
      end
      UPC_INS2: begin
        w.addr     = ADDR_FREE;
        w.text_we  = 1'b1;
        w.link_we  = LWE_ON;
        w.link_src = LSRC_RD;
      end
      UPC_INS3: begin
        w.addr     = ADDR_NODE;
        w.link_we  = LWE_ON;
        w.link_src = LSRC_FREE;
        w.free_op  = FREE_INC;
        w.emit     = EMIT_INS_OK;
        w.cond     = COND_ALWAYS;
      end
      UPC_INS_HEAD: begin
        w.addr     = ADDR_FREE;
        w.text_we  = 1'b1;
        w.link_we  = LWE_ON;
        w.link_src = LSRC_HEAD;
        w.head_op  = HEAD_FREE;
        w.free_op  = FREE_INC;
        w.emit     = EMIT_INS_OK;
        w.cond     = COND_ALWAYS;
      end
      UPC_INS_FULL: begin
        w.emit = EMIT_INS_FULL;
        w.cond = COND_ALWAYS;
      end
      UPC_DEL0: begin
        w.addr   = ADDR_NODE;
        w.mem_rd = 1'b1;
        w.cond   = COND_NODE_OUT;
        w.tgt    = UPC_DEL_HEAD;
      end
      UPC_DEL1: begin
        w.vic_op = VIC_RD;
        w.cond   = COND_RD_OUT;
        w.tgt    = UPC_DEL_NONE;
      end
      UPC_DEL2: begin
        w.addr   = ADDR_VICTIM;
        w.mem_rd = 1'b1;
      end
      UPC_DEL3: begin
        w.addr     = ADDR_NODE;
        w.link_we  = LWE_IF_NODE;
        w.link_src = LSRC_RD;
        w.head_op  = HEAD_RD_IF_NO_NODE;
        w.emit     = EMIT_DEL_OK;
        w.cond     = COND_ALWAYS;
      end
      UPC_DEL_HEAD: begin
        w.vic_op = VIC_HEAD;
        w.cond   = COND_HEAD_IN;
        w.tgt    = UPC_DEL2;
      end
      UPC_DEL_NONE: begin
        w.emit = EMIT_DEL_NONE;
        w.cond = COND_ALWAYS;
      end
      UPC_RD0: begin
        w.addr   = ADDR_NODE;
        w.mem_rd = 1'b1;
        w.cond   = COND_NODE_OUT;
        w.tgt    = UPC_RD_OUT;
      end
      UPC_RD1: begin
        w.emit = EMIT_RD_OK;
        w.cond = COND_ALWAYS;
      end
      UPC_RD_OUT: begin
        w.emit = EMIT_RD_OUT;
        w.cond = COND_ALWAYS;
      end
      default: w = CTL_NOP;
    endcase
    return w;
  endfunction

endpackage

[rtl/core/array_linked_list_engine_core.sv]
// top level of the array linked-list engine: microcoded sequencer, node pool and stream ports
//
// Linked-list engine over a fixed pool of POOL_NODES nodes, each holding TEXT_BYTES bytes of
// text and an 11-bit signed next link, plus a head pointer and a free-slot counter. Every input
// word is one operation selected by in_tuser: begin, load, insert, delete or read. Insert,
// delete and read each produce one output word; begin, load and unknown codes produce none.
// The engine works on one operation at a time: in_tready is high only while the sequencer sits
// idle, and it drops for the duration of the operation. A result that cannot leave because
// out_tready is low holds the sequencer on the step that produces it. The microcode step count
// is set by the single port on the link memory and its registered read: delete needs two
// dependent link reads and then a write. The result sits in an output register, so the next
// operation is taken while an earlier result still waits. Pool memories are not cleared at
// reset; reading a slot that was never written gives unspecified text and link.

module array_linked_list_engine_core #(
  parameter int POOL_NODES = 1024,
  parameter int TEXT_BYTES = 7
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // operation in
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [alle_pkg::IN_TUSER_W-1:0]    in_tuser,   // mode
  input  logic [alle_pkg::IN_TDATA_W-1:0]    in_tdata,   // node_index, node_value, link_index
  // result out
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [alle_pkg::OUT_TUSER_W-1:0]   out_tuser,  // result_kind
  output logic [alle_pkg::OUT_TDATA_W-1:0]   out_tdata   // result_index, result_value,
                                                         // result_link, status
);
  import alle_pkg::*;

  localparam int AW    = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
  localparam int FW    = $clog2(POOL_NODES + 1);
  localparam int TXT_W = (8 * TEXT_BYTES < VAL_W) ? 8 * TEXT_BYTES : VAL_W;

  // node pool
  logic [TXT_W-1:0] text_mem [POOL_NODES];
  logic [IDX_W-1:0] link_mem [POOL_NODES];

  // sequencer and list state
  upc_t             pc_r, pc_nxt;
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [FW-1:0]    free_r, free_nxt;

  // latched operation and working registers
  logic [IDX_W-1:0] node_r;
  logic [TXT_W-1:0] text_r;
  logic [IDX_W-1:0] link_in_r;
  logic [IDX_W-1:0] victim_r, victim_nxt;
  logic [TXT_W-1:0] rd_text_r;
  logic [IDX_W-1:0] rd_link_r;

  // output register
  logic             out_valid_r, out_valid_nxt;
  logic [1:0]       out_kind_r, out_kind_nxt;
  logic [IDX_W-1:0] out_index_r, out_index_nxt;
  logic [VAL_W-1:0] out_value_r, out_value_nxt;
  logic [IDX_W-1:0] out_link_r, out_link_nxt;
  logic [ST_W-1:0]  out_st_r, out_st_nxt;

  // control
  ctl_t             ctl;
  logic             in_acc;
  logic             stall;
  logic             step_en;
  logic             node_in;
  logic             full;
  logic             cond_hit;
  logic             text_we;
  logic             link_we;
  logic             mem_rd;
  logic [AW-1:0]    mem_addr;
  logic [IDX_W-1:0] link_wdata;
  logic [31:0]      node_ext;
  logic [31:0]      victim_ext;
  logic [31:0]      free_ext;
  logic [IDX_W-1:0] free_idx;
  logic [63:0]      rd_text_ext;

  // a pointer names a pool slot only when non-negative and below the pool size
  function automatic logic in_pool(input logic [IDX_W-1:0] p);
    logic [31:0] pu;
    pu = 32'(p);
    return !p[IDX_W-1] && (pu < 32'(POOL_NODES));
  endfunction

  assign in_tready = (pc_r == UPC_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    ctl         = alle_ucode(pc_r);
    node_ext    = 32'(node_r);
    victim_ext  = 32'(victim_r);
    free_ext    = 32'(free_r);
    free_idx    = free_ext[IDX_W-1:0];
    rd_text_ext = 64'(rd_text_r);
    node_in     = in_pool(node_r);
    full        = (free_ext >= 32'(POOL_NODES));

    // an emitting step waits for room in the output register
    stall   = (ctl.emit != EMIT_NONE) && out_valid_r && !out_tready;
    step_en = (pc_r != UPC_IDLE) && !stall;

    case (ctl.cond)
      COND_NEVER:    cond_hit = 1'b0;
      COND_ALWAYS:   cond_hit = 1'b1;
      COND_FULL:     cond_hit = full;
      COND_NODE_OUT: cond_hit = !node_in;
      COND_RD_OUT:   cond_hit = !in_pool(rd_link_r);
      COND_HEAD_IN:  cond_hit = in_pool(head_r);
      default:       cond_hit = 1'b0;
    endcase

    // next microcode address
    pc_nxt = pc_r;
    if (pc_r == UPC_IDLE) begin
      if (in_acc) begin
        pc_nxt = alle_entry(in_tuser);
      end
    end else if (step_en) begin
      pc_nxt = cond_hit ? ctl.tgt : upc_t'(pc_r + 5'd1);
    end

    // pool port
    case (ctl.addr)
      ADDR_NODE:   mem_addr = node_ext[AW-1:0];
      ADDR_FREE:   mem_addr = free_r[AW-1:0];
      ADDR_VICTIM: mem_addr = victim_ext[AW-1:0];
      default:     mem_addr = node_ext[AW-1:0];
    endcase

    case (ctl.link_src)
      LSRC_IN:   link_wdata = link_in_r;
      LSRC_HEAD: link_wdata = head_r;
      LSRC_RD:   link_wdata = rd_link_r;
      LSRC_FREE: link_wdata = free_idx;
      default:   link_wdata = link_in_r;
    endcase

    text_we = step_en && ctl.text_we;
    mem_rd  = step_en && ctl.mem_rd;
    case (ctl.link_we)
      LWE_ON:      link_we = step_en;
      LWE_IF_NODE: link_we = step_en && node_in;
      default:     link_we = 1'b0;
    endcase

    // list state
    head_nxt   = head_r;
    free_nxt   = free_r;
    victim_nxt = victim_r;
    if (step_en) begin
      case (ctl.head_op)
        HEAD_NODE:          head_nxt = node_r;
        HEAD_FREE:          head_nxt = free_idx;
        HEAD_RD_IF_NO_NODE: head_nxt = node_in ? head_r : rd_link_r;
        default:            head_nxt = head_r;
      endcase
      case (ctl.free_op)
        FREE_CLR: free_nxt = '0;
        FREE_INC: free_nxt = free_r + FW'(1);
        default:  free_nxt = free_r;
      endcase
      case (ctl.vic_op)
        VIC_RD:   victim_nxt = rd_link_r;
        VIC_HEAD: victim_nxt = head_r;
        default:  victim_nxt = victim_r;
      endcase
    end

    // result word
    out_valid_nxt = out_valid_r && !out_tready;
    out_kind_nxt  = out_kind_r;
    out_index_nxt = out_index_r;
    out_value_nxt = out_value_r;
    out_link_nxt  = out_link_r;
    out_st_nxt    = out_st_r;
    if (step_en && (ctl.emit != EMIT_NONE)) begin
      out_valid_nxt = 1'b1;
      out_value_nxt = '0;
      out_link_nxt  = '0;
      out_st_nxt    = ST_OK;
      case (ctl.emit)
        EMIT_INS_OK: begin
          out_kind_nxt  = KIND_INSERT;
          out_index_nxt = free_idx;
        end
        EMIT_INS_FULL: begin
          out_kind_nxt  = KIND_INSERT;
          out_index_nxt = NIL;
          out_st_nxt    = ST_FULL;
        end
        EMIT_DEL_OK: begin
          out_kind_nxt  = KIND_DELETE;
          out_index_nxt = victim_r;
          out_value_nxt = rd_text_ext[VAL_W-1:0];
        end
        EMIT_DEL_NONE: begin
          out_kind_nxt  = KIND_DELETE;
          out_index_nxt = NIL;
          out_st_nxt    = ST_EMPTY;
        end
        EMIT_RD_OK: begin
          out_kind_nxt  = KIND_READ;
          out_index_nxt = node_r;
          out_value_nxt = rd_text_ext[VAL_W-1:0];
          out_link_nxt  = rd_link_r;
        end
        EMIT_RD_OUT: begin
          out_kind_nxt  = KIND_READ;
          out_index_nxt = node_r;
          out_link_nxt  = NIL;
        end
        default: begin
          out_valid_nxt = out_valid_r && !out_tready;
        end
      endcase
    end
  end

  // sequencer, list state and output handshake
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= UPC_IDLE;
      head_r      <= NIL;
      free_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      pc_r        <= pc_nxt;
      head_r      <= head_nxt;
      free_r      <= free_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      node_r    <= in_tdata[IN_NODE_LSB +: IDX_W];
      text_r    <= in_tdata[IN_VALUE_LSB +: TXT_W];
      link_in_r <= in_tdata[IN_LINK_LSB +: IDX_W];
    end
    victim_r    <= victim_nxt;
    out_kind_r  <= out_kind_nxt;
    out_index_r <= out_index_nxt;
    out_value_r <= out_value_nxt;
    out_link_r  <= out_link_nxt;
    out_st_r    <= out_st_nxt;
  end

  // text memory, single port with registered read
  always_ff @(posedge clk) begin
    if (text_we) begin
      text_mem[mem_addr] <= text_r;
    end
    if (mem_rd) begin
      rd_text_r <= text_mem[mem_addr];
    end
  end

  // link memory, single port with registered read
  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[mem_addr] <= link_wdata;
    end
    if (mem_rd) begin
      rd_link_r <= link_mem[mem_addr];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_kind_r;
  assign out_tdata  = {out_st_r, out_link_r, out_value_r, out_index_r};

endmodule

[rtl/core/alle_checker.sv]
// port-level assertions for the array linked-list engine, bound to the top level
module alle_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_tvalid,
  input logic                             in_tready,
  input logic [alle_pkg::IN_TUSER_W-1:0]  in_tuser,
  input logic                             out_tvalid,
  input logic                             out_tready,
  input logic [alle_pkg::OUT_TUSER_W-1:0] out_tuser,
  input logic [alle_pkg::OUT_TDATA_W-1:0] out_tdata
);
  import alle_pkg::*;

  // no result word straight after reset
  a_reset_quiet: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result word valid after reset");

  // a waiting result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result word changed while stalled");

  // a known operation keeps the engine busy in the cycle after it is taken
  a_busy_after_op: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && (in_tuser <= MODE_READ) |=> !in_tready)
    else $error("engine ready straight after taking an operation");

  // a refused insert names no node
  a_full_nil: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_INSERT && out_tdata[OUT_ST_LSB +: ST_W] == ST_FULL
    |-> out_tdata[OUT_INDEX_LSB +: IDX_W] == NIL)
    else $error("pool-full insert carries an index");

  // a read of a negative node gives empty text and an end link
  a_read_out: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_READ && out_tdata[OUT_INDEX_LSB + IDX_W - 1]
    |-> out_tdata[OUT_ST_LSB +: ST_W] == ST_OK && out_tdata[OUT_VALUE_LSB +: VAL_W] == '0
        && out_tdata[OUT_LINK_LSB +: IDX_W] == NIL)
    else $error("read of a node outside the pool returned data");

endmodule

bind array_linked_list_engine_core alle_checker u_alle_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tuser   (in_tuser),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tuser  (out_tuser),
  .out_tdata  (out_tdata)
);

[test/array_linked_list_engine_core_tb.sv]
// testbench for the array linked-list engine: directed operations, random list traffic, full pool
`timescale 1ns / 100ps

module array_linked_list_engine_core_tb;
  import alle_pkg::*;

  localparam int POOL       = 1024;
  localparam int TXT        = 7;
  localparam int RAND_ITEMS = 600;
  localparam int DIR_ROWS   = 27;
  localparam int LIMIT      = 600000;
  localparam int TAIL       = 20;

  // operation codes the engine ignores
  localparam logic [2:0] MODE_SPARE5 = 3'd5;
  localparam logic [2:0] MODE_SPARE6 = 3'd6;
  localparam logic [2:0] MODE_SPARE7 = 3'd7;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [VAL_W-1:0] txt_t;

  localparam txt_t TXT_MASK = (TXT >= 8) ? '1 : txt_t'((64'd1 << (8 * TXT)) - 64'd1);

  typedef struct packed {
    logic [1:0]      kind;
    idx_t            index;
    txt_t            value;
    idx_t            link;
    logic [ST_W-1:0] status;
  } answer_t;

  typedef struct packed {
    logic [2:0] mode;
    idx_t       node;
    txt_t       value;
    idx_t       link;
    bit         typed;
    answer_t    ans;
  } dir_row_t;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TUSER_W-1:0]  in_tuser   = '0;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TUSER_W-1:0] out_tuser;
  logic [OUT_TDATA_W-1:0] out_tdata;

  always #6 clk = ~clk;

  array_linked_list_engine_core #(
    .POOL_NODES(POOL),
    .TEXT_BYTES(TXT)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tuser (out_tuser),
    .out_tdata (out_tdata)
  );

  // shadow of the node pool, head pointer and free counter
  txt_t node_text    [POOL];
  idx_t node_link    [POOL];
  bit   node_written [POOL];
  idx_t head_ptr;
  int   free_cnt;
  int   top_written;
  idx_t walk_ptr;

  answer_t  pending_answers[$];
  answer_t  front_ans;
  dir_row_t dir_tab [DIR_ROWS];

  int  errors       = 0;
  int  cycles       = 0;
  int  words_sent   = 0;
  int  rand_count   = 0;
  int  results_seen = 0;
  int  n_insert     = 0;
  int  n_delete     = 0;
  int  n_read       = 0;
  int  n_full       = 0;
  int  n_empty      = 0;
  int  rx_hold      = 0;
  bit  tx_calm      = 1'b0;
  bit  rx_calm      = 1'b0;

  function automatic bit in_range(idx_t p);
    return ($signed(p) >= 0) && ($signed(p) < POOL);
  endfunction

  // an operation must never look at a slot that was never written
  function automatic bit safe_op(logic [2:0] mode, idx_t node);
    idx_t victim;
    case (mode)
      MODE_READ:   return !in_range(node) || node_written[node];
      MODE_INSERT: return free_cnt >= POOL || !in_range(node) || node_written[node];
      MODE_DELETE: begin
        if (in_range(node)) begin
          if (!node_written[node]) return 1'b0;
          victim = node_link[node];
        end else begin
          victim = head_ptr;
        end
        return !in_range(victim) || node_written[victim];
      end
      default: return 1'b1;
    endcase
  endfunction

  function automatic void store_node(int slot, txt_t text, idx_t link);
    node_text[slot]    = text;
    node_link[slot]    = link;
    node_written[slot] = 1'b1;
    if (slot > top_written) top_written = slot;
  endfunction

  // list engine predictor: updates the shadow state, returns the answer if one is due
  function automatic bit list_engine_step(logic [2:0] mode, idx_t node, txt_t value,
                                          idx_t link, output answer_t ans);
    idx_t victim;
    txt_t text;
    int   fresh;
    text = value & TXT_MASK;
    ans  = '0;
    case (mode)
      MODE_BEGIN: begin
        head_ptr = node;
        free_cnt = 0;
        return 1'b0;
      end
      MODE_LOAD: begin
        if (free_cnt < POOL) begin
          store_node(free_cnt, text, link);
          free_cnt++;
        end
        return 1'b0;
      end
      MODE_INSERT: begin
        ans.kind = KIND_INSERT;
        if (free_cnt >= POOL) begin
          ans.index  = NIL;
          ans.status = ST_FULL;
        end else begin
          fresh = free_cnt;
          if (!in_range(node)) begin
            store_node(fresh, text, head_ptr);
            head_ptr = idx_t'(fresh);
          end else begin
            store_node(fresh, text, node_link[node]);
            node_link[node] = idx_t'(fresh);
          end
          free_cnt++;
          ans.index  = idx_t'(fresh);
          ans.status = ST_OK;
        end
        return 1'b1;
      end
      MODE_DELETE: begin
        ans.kind = KIND_DELETE;
        victim   = in_range(node) ? node_link[node] : head_ptr;
        if (!in_range(victim)) begin
          ans.index  = NIL;
          ans.status = ST_EMPTY;
        end else begin
          if (in_range(node)) node_link[node] = node_link[victim];
          else head_ptr = node_link[victim];
          ans.index  = victim;
          ans.value  = node_text[victim];
          ans.status = ST_OK;
        end
        return 1'b1;
      end
      MODE_READ: begin
        ans.kind   = KIND_READ;
        ans.index  = node;
        ans.status = ST_OK;
        if (in_range(node)) begin
          ans.value = node_text[node];
          ans.link  = node_link[node];
        end else begin
          ans.link = NIL;
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  function automatic int sender_gap();
    int r;
    r = $urandom_range(0, 99);
    if (tx_calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  function automatic int stall_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return $urandom_range(0, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic txt_t random_text();
    txt_t t;
    t = txt_t'({$urandom, $urandom});
    if ($urandom_range(0, 1) == 1)
      for (int b = 0; b < TXT; b++) t[8*b +: 8] = 8'($urandom_range(32, 126));
    return t;
  endfunction

  // a node that holds data, preferably one on the walk through the list
  function automatic idx_t known_node();
    idx_t p;
    if (in_range(walk_ptr) && node_written[walk_ptr] && $urandom_range(0, 1) == 1)
      return walk_ptr;
    for (int i = 0; i < 8; i++) begin
      p = idx_t'($urandom_range(0, (top_written < 0) ? 0 : top_written));
      if (node_written[p]) return p;
    end
    return NIL;
  endfunction

  // one word on the input stream; waits for the handshake
  task automatic send_word(logic [2:0] mode, idx_t node, txt_t value, idx_t link);
    int gap;
    gap = sender_gap();
    repeat (gap) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {2'b00, link, value, node};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    words_sent++;
  endtask

  // predict, queue the answer (the typed one where given), then send
  task automatic issue(logic [2:0] mode, idx_t node, txt_t value, idx_t link,
                       bit typed, answer_t typed_ans);
    answer_t ans;
    bit      due;
    due = list_engine_step(mode, node, value, link, ans);
    if (due) begin
      if (typed) ans = typed_ans;
      pending_answers.push_back(ans);
      case (ans.kind)
        KIND_INSERT: n_insert++;
        KIND_DELETE: n_delete++;
        default:     n_read++;
      endcase
      if (ans.status == ST_FULL)  n_full++;
      if (ans.status == ST_EMPTY) n_empty++;
    end
    if (mode == MODE_READ) walk_ptr = in_range(ans.link) ? ans.link : head_ptr;
    send_word(mode, node, value, link);
  endtask

  task automatic random_op();
    logic [2:0] mode;
    idx_t       node;
    idx_t       link;
    txt_t       value;
    int         pick;
    int         tries;
    tries = 0;
    do begin
      pick  = $urandom_range(0, 99);
      value = random_text();
      node  = NIL;
      link  = NIL;
      if (pick < 25) begin
        mode = MODE_INSERT;
        if ($urandom_range(0, 2) != 0) node = known_node();
      end else if (pick < 45) begin
        mode = MODE_DELETE;
        if ($urandom_range(0, 2) != 0) node = known_node();
      end else if (pick < 70) begin
        mode = MODE_READ;
        node = (in_range(walk_ptr) && node_written[walk_ptr]) ? walk_ptr : known_node();
      end else if (pick < 88) begin
        mode = MODE_LOAD;
        node = idx_t'($urandom);
        case ($urandom_range(0, 9))
          0, 1, 2, 3: link = idx_t'(free_cnt + 1);
          4, 5:       link = known_node();
          6:          link = idx_t'($urandom);
          default:    link = NIL;
        endcase
      end else if (pick < 93) begin
        mode = MODE_BEGIN;
        case ($urandom_range(0, 2))
          0:       node = NIL;
          1:       node = known_node();
          default: node = idx_t'($urandom);
        endcase
      end else if (pick < 96) begin
        mode  = MODE_SPARE5 + 3'($urandom_range(0, 2));
        node  = idx_t'($urandom);
        link  = idx_t'($urandom);
      end else begin
        // reads off the ends of the pool: every negative index answers as null
        mode = MODE_READ;
        node = ($urandom_range(0, 1) == 1) ? NIL : idx_t'($urandom_range(1024, 2047));
      end
      tries++;
    end while (!safe_op(mode, node) && tries < 16);
    if (!safe_op(mode, node)) begin
      mode = MODE_READ;
      node = NIL;
    end
    if (mode < MODE_SPARE5) rand_count++;
    issue(mode, node, value, link, 1'b0, '0);
  endtask

  task automatic check_field(string name, logic [VAL_W-1:0] want, logic [VAL_W-1:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want, got);
      errors++;
    end
  endtask

  // result side: every word taken is matched against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (pending_answers.size() == 0) begin
        $display("%0t ns: unexpected result word, expected none, got kind %h data %h",
                 $time, out_tuser, out_tdata);
        errors++;
      end else begin
        front_ans = pending_answers.pop_front();
        check_field("result_kind",  front_ans.kind,   out_tuser);
        check_field("result_index", front_ans.index,  out_tdata[OUT_INDEX_LSB +: IDX_W]);
        check_field("result_value", front_ans.value,  out_tdata[OUT_VALUE_LSB +: VAL_W]);
        check_field("result_link",  front_ans.link,   out_tdata[OUT_LINK_LSB +: IDX_W]);
        check_field("status",       front_ans.status, out_tdata[OUT_ST_LSB +: ST_W]);
      end
    end
  end

  // result-side stalls, mostly short, now and then long, with calm stretches
  always @(posedge clk) begin
    if (rx_hold > 0) begin
      out_tready <= 1'b0;
      rx_hold    <= rx_hold - 1;
    end else if (!rx_calm && $urandom_range(0, 99) < 25) begin
      out_tready <= 1'b0;
      rx_hold    <= stall_len();
    end else begin
      out_tready <= 1'b1;
    end
  end

  // cycle count, calm stretches and the overall timeout
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles % 1500 == 0) begin
      tx_calm <= ($urandom_range(0, 3) == 0);
      rx_calm <= ($urandom_range(0, 3) == 0);
    end
    if (cycles > LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_answers.size());
      $display("FAIL array_linked_list_engine_core");
      $finish;
    end
  end

  initial begin
    head_ptr    = NIL;
    free_cnt    = 0;
    top_written = -1;
    walk_ptr    = NIL;
    for (int i = 0; i < POOL; i++) node_written[i] = 1'b0;

    // directed words: empty list, head and mid-list insert and delete, nulls, spare codes
    dir_tab[0]  = '{MODE_READ,   NIL,     '0,  '0,  1'b1, '{KIND_READ,   NIL,   '0, NIL, ST_OK}};
    dir_tab[1]  = '{MODE_DELETE, NIL,     '0,  '0,  1'b1, '{KIND_DELETE, NIL,   '0, '0, ST_EMPTY}};
    dir_tab[2]  = '{MODE_INSERT, NIL,     '1,  '0,  1'b1, '{KIND_INSERT, 11'd0, '0, '0, ST_OK}};
    dir_tab[3]  = '{MODE_INSERT, 11'd0,   '0,  '1,  1'b1, '{KIND_INSERT, 11'd1, '0, '0, ST_OK}};
    dir_tab[4]  = '{MODE_LOAD,   11'h3FF, 56'h41424344454647, 11'd0, 1'b0, '0};
    dir_tab[5]  = '{MODE_LOAD,   11'd0,   56'h20202020202020, NIL,   1'b0, '0};
    dir_tab[6]  = '{MODE_READ,   11'd0,   '0,  '0,  1'b0, '0};
    dir_tab[7]  = '{MODE_READ,   11'd2,   '1,  '1,  1'b0, '0};
    dir_tab[8]  = '{MODE_READ,   11'h7FE, '0,  '0,  1'b1, '{KIND_READ, 11'h7FE, '0, NIL, ST_OK}};
    dir_tab[9]  = '{MODE_SPARE5, '1,      '1,  '1,  1'b0, '0};
    dir_tab[10] = '{MODE_SPARE6, '0,      '0,  '0,  1'b0, '0};
    dir_tab[11] = '{MODE_SPARE7, 11'h400, 56'h55AA55AA55AA55, 11'h2AA, 1'b0, '0};
    dir_tab[12] = '{MODE_DELETE, 11'd0,   '0,  '0,  1'b0, '0};
    dir_tab[13] = '{MODE_DELETE, 11'd0,   '0,  '0,  1'b1, '{KIND_DELETE, NIL, '0, '0, ST_EMPTY}};
    dir_tab[14] = '{MODE_DELETE, NIL,     '0,  '0,  1'b0, '0};
    dir_tab[15] = '{MODE_DELETE, NIL,     '0,  '0,  1'b1, '{KIND_DELETE, NIL, '0, '0, ST_EMPTY}};
    dir_tab[16] = '{MODE_BEGIN,  11'd2,   '0,  '0,  1'b0, '0};
    dir_tab[17] = '{MODE_DELETE, 11'd2,   '0,  '0,  1'b0, '0};
    dir_tab[18] = '{MODE_INSERT, 11'd3,   56'h1, '0, 1'b0, '0};
    dir_tab[19] = '{MODE_READ,   11'd3,   '0,  '0,  1'b0, '0};
    dir_tab[20] = '{MODE_DELETE, NIL,     '0,  '0,  1'b0, '0};
    dir_tab[21] = '{MODE_BEGIN,  11'h3FF, '0,  '0,  1'b0, '0};
    dir_tab[22] = '{MODE_INSERT, NIL,     56'h7E7E7E7E7E7E7E, '0, 1'b0, '0};
    dir_tab[23] = '{MODE_READ,   11'd0,   '0,  '0,  1'b0, '0};
    dir_tab[24] = '{MODE_LOAD,   11'd0,   '0,  11'h400, 1'b0, '0};
    dir_tab[25] = '{MODE_READ,   11'd1,   '0,  '0,  1'b0, '0};
    dir_tab[26] = '{MODE_DELETE, 11'd1,   '0,  '0,  1'b1, '{KIND_DELETE, NIL, '0, '0, ST_EMPTY}};

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < DIR_ROWS; r++)
      issue(dir_tab[r].mode, dir_tab[r].node, dir_tab[r].value, dir_tab[r].link,
            dir_tab[r].typed, dir_tab[r].ans);
    walk_ptr = head_ptr;

    // random traffic, now and then a fresh list laid down by begin and a run of chained loads
    while (rand_count < RAND_ITEMS) begin
      if ($urandom_range(0, 29) == 0) begin
        int run;
        run = $urandom_range(2, 12);
        issue(MODE_BEGIN, 11'd0, random_text(), NIL, 1'b0, '0);
        for (int k = 0; k < run; k++)
          issue(MODE_LOAD, idx_t'($urandom), random_text(),
                (k == run - 1) ? NIL : idx_t'(k + 1), 1'b0, '0);
        walk_ptr   = 11'd0;
        rand_count = rand_count + run + 1;
      end else begin
        random_op();
      end
    end

    // fill the whole pool as one chain, then work on it while full
    issue(MODE_BEGIN, 11'd0, '0, NIL, 1'b0, '0);
    while (free_cnt < POOL)
      issue(MODE_LOAD, idx_t'($urandom), random_text(),
            (free_cnt == POOL - 1) ? NIL : idx_t'(free_cnt + 1), 1'b0, '0);
    walk_ptr = 11'd0;
    issue(MODE_INSERT, NIL, random_text(), NIL, 1'b1,
          answer_t'{KIND_INSERT, NIL, '0, '0, ST_FULL});
    issue(MODE_LOAD, 11'd0, random_text(), 11'd5, 1'b0, '0);
    issue(MODE_READ, 11'h3FF, '0, '0, 1'b0, '0);
    repeat (40) random_op();

    in_tvalid <= 1'b0;
    while (pending_answers.size() != 0) @(posedge clk);
    repeat (TAIL) @(posedge clk);

    $display("sent %0d words over %0d cycles; checked %0d results", words_sent, cycles,
             results_seen);
    $display("  %0d inserts (%0d on a full pool), %0d deletes (%0d with no target), %0d reads",
             n_insert, n_full, n_delete, n_empty, n_read);
    if (errors == 0) begin
      $display("PASS array_linked_list_engine_core");
    end else begin
      $display("FAIL array_linked_list_engine_core");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/alle_pkg.sv
rtl/core/array_linked_list_engine_core.sv
rtl/core/alle_checker.sv
test/array_linked_list_engine_core_tb.sv
